/* rtl/core/hgrm_pkg.sv */
`default_nettype none
package hgrm_pkg;

    localparam int GRID_SIDE_DEF = 400;
    localparam int CELL_MM_DEF   = 10;

    localparam int COORD_W = 16;
    localparam int Y_W     = 14;
    localparam int CNT_W   = 19;
    localparam int RC_W    = 9;
    localparam int ADDR_W  = 20;
    localparam int TAG_W   = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TAG_W-1:0] TAG_MAX = '1;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_CLR  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [2:0] CFG_XMIN = 3'd0;
    localparam logic [2:0] CFG_XMAX = 3'd1;
    localparam logic [2:0] CFG_ZMIN = 3'd2;
    localparam logic [2:0] CFG_ZMAX = 3'd3;
    localparam logic [2:0] CFG_KEEP = 3'd4;

    localparam logic [1:0] K_EMIT = 2'd0;
    localparam logic [1:0] K_ADD  = 2'd1;
    localparam logic [1:0] K_CLR  = 2'd2;
    localparam logic [1:0] K_READ = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_min;
        logic signed [COORD_W-1:0] x_max;
        logic signed [COORD_W-1:0] z_min;
        logic signed [COORD_W-1:0] z_max;
        logic                      keep;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            kind;
        logic [RC_W-1:0]       row;
        logic [RC_W-1:0]       col;
        logic [ADDR_W-1:0]     addr;
        logic signed [Y_W-1:0] y;
    } t_cmd;

    typedef struct packed {
        logic signed [Y_W-1:0] mean;
        logic [CNT_W-1:0]      cnt;
        logic [TAG_W-1:0]      tag;
    } t_cell;

endpackage
`default_nettype wire

/* rtl/core/hgrm_front.sv */
`default_nettype none
module hgrm_front #(
    parameter int GRID_SIDE = hgrm_pkg::GRID_SIDE_DEF,
    parameter int CELL_MM   = hgrm_pkg::CELL_MM_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    output logic                                   o_ready,
    input  wire  [1:0]                             i_action,
    input  wire  signed [hgrm_pkg::COORD_W-1:0]    i_x,
    input  wire  signed [hgrm_pkg::COORD_W-1:0]    i_z,
    input  wire  signed [hgrm_pkg::Y_W-1:0]        i_y,
    input  wire  [hgrm_pkg::RC_W-1:0]              i_rr,
    input  wire  [hgrm_pkg::RC_W-1:0]              i_rc,
    input  hgrm_pkg::t_cfg                         i_cfg,
    output logic                                   o_push,
    output hgrm_pkg::t_cmd                         o_cmd,
    input  wire                                    i_full
);
    import hgrm_pkg::*;

    localparam int SH    = 24;
    localparam int RECIP = (1 << SH) / CELL_MM;
    localparam int KOFF  = (32768 + CELL_MM - 1) / CELL_MM;
    localparam int KC    = KOFF * CELL_MM;
    localparam int UW    = 17;
    localparam int RW    = $clog2(GRID_SIDE);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIV  = 3'd1;
    localparam logic [2:0] F_COR  = 3'd2;
    localparam logic [2:0] F_BIN  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]            r_st, n_st;
    logic [1:0]            r_act;
    logic signed [Y_W-1:0] r_y;
    logic [RC_W-1:0]       r_rr, r_rc;
    logic [UW-1:0]         r_ux, r_uz, r_qx, r_qz;
    logic                  r_win;
    t_cmd                  r_cmd;

    logic [UW+24:0]        prx, prz;
    logic [UW-1:0]         remx, remz;
    logic signed [18:0]    cols, rows;
    logic                  grid_ok, rd_ok;
    logic [ADDR_W-1:0]     srow, scol, addr;
    t_cmd                  cmd;

    assign o_ready = (r_st == F_IDLE);
    assign o_push  = (r_st == F_PUSH);
    assign o_cmd   = r_cmd;

    assign prx  = (UW+25)'(r_ux) * (UW+25)'(RECIP);
    assign prz  = (UW+25)'(r_uz) * (UW+25)'(RECIP);
    assign remx = UW'(r_ux - UW'(r_qx * CELL_MM));
    assign remz = UW'(r_uz - UW'(r_qz * CELL_MM));

    assign cols    = $signed(19'(r_qx)) + $signed(19'(GRID_SIDE / 2 - KOFF));
    assign rows    = $signed(19'(r_qz)) + $signed(19'(GRID_SIDE / 2 - KOFF));
    assign grid_ok = !cols[18] && !rows[18] &&
                     (cols < $signed(19'(GRID_SIDE))) && (rows < $signed(19'(GRID_SIDE)));
    assign rd_ok   = (32'(r_rr) < GRID_SIDE) && (32'(r_rc) < GRID_SIDE);

    always_comb begin
        if (r_act == ACT_ADD) begin
            srow = ADDR_W'(rows[RW-1:0]);
            scol = ADDR_W'(cols[RW-1:0]);
        end else begin
            srow = ADDR_W'(r_rr);
            scol = ADDR_W'(r_rc);
        end
        addr = ADDR_W'(srow * ADDR_W'(GRID_SIDE)) + scol;
        cmd      = '0;
        cmd.addr = addr;
        cmd.y    = r_y;
        case (r_act)
            ACT_ADD: begin
                if (r_win && grid_ok) begin
                    cmd.kind = K_ADD;
                    cmd.row  = RC_W'(rows);
                    cmd.col  = RC_W'(cols);
                end else begin
                    cmd.kind = K_EMIT;
                end
            end
            ACT_CLR: begin
                cmd.kind = K_CLR;
            end
            ACT_READ: begin
                cmd.kind = rd_ok ? K_READ : K_EMIT;
                cmd.row  = r_rr;
                cmd.col  = r_rc;
            end
            default: begin
                cmd.kind = K_EMIT;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            F_IDLE: if (i_valid) n_st = F_DIV;
            F_DIV:  n_st = F_COR;
            F_COR:  n_st = F_BIN;
            F_BIN:  n_st = F_PUSH;
            F_PUSH: if (!i_full) n_st = F_IDLE;
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            F_IDLE: begin
                r_act <= i_action;
                r_y   <= i_y;
                r_rr  <= i_rr;
                r_rc  <= i_rc;
                r_ux  <= UW'({i_x[COORD_W-1], i_x} + UW'(KC));
                r_uz  <= UW'({i_z[COORD_W-1], i_z} + UW'(KC));
                r_win <= (i_x > i_cfg.x_min) && (i_x < i_cfg.x_max) &&
                         (i_z > i_cfg.z_min) && (i_z < i_cfg.z_max);
            end
            F_DIV: begin
                r_qx <= prx[SH+UW-1:SH];
                r_qz <= prz[SH+UW-1:SH];
            end
            F_COR: begin
                r_qx <= r_qx + UW'(remx >= UW'(CELL_MM));
                r_qz <= r_qz + UW'(remz >= UW'(CELL_MM));
            end
            F_BIN: begin
                r_cmd <= cmd;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/hgrm_fifo.sv */
`default_nettype none
module hgrm_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  hgrm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  wire            i_pop,
    output hgrm_pkg::t_cmd o_head,
    output logic           o_empty
);
    import hgrm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_pop && !o_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wp] <= i_cmd;
    end

endmodule
`default_nettype wire

/* rtl/core/hgrm_back.sv */
`default_nettype none
module hgrm_back #(
    parameter int GRID_SIDE = hgrm_pkg::GRID_SIDE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  hgrm_pkg::t_cmd                     i_head,
    input  wire                                i_empty,
    output logic                               o_pop,
    input  wire                                i_keep,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_ok,
    output logic [hgrm_pkg::RC_W-1:0]          o_row,
    output logic [hgrm_pkg::RC_W-1:0]          o_col,
    output logic signed [hgrm_pkg::Y_W-1:0]    o_mean,
    output logic [hgrm_pkg::CNT_W-1:0]         o_cnt
);
    import hgrm_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int DVW   = CNT_W + 1;

    localparam logic [3:0] B_INIT  = 4'd0;
    localparam logic [3:0] B_IDLE  = 4'd1;
    localparam logic [3:0] B_LOAD  = 4'd2;
    localparam logic [3:0] B_MUL   = 4'd3;
    localparam logic [3:0] B_NUM   = 4'd4;
    localparam logic [3:0] B_DIV   = 4'd5;
    localparam logic [3:0] B_WR    = 4'd6;
    localparam logic [3:0] B_EMIT  = 4'd7;
    localparam logic [3:0] B_RB_RD = 4'd8;
    localparam logic [3:0] B_RB_WR = 4'd9;

    t_cell                 r_mem [DEPTH];
    t_cell                 r_rdata;
    logic [AW-1:0]         rd_addr, wr_addr;
    t_cell                 wr_data;
    logic                  we;

    logic [3:0]            r_st;
    logic [AW-1:0]         r_sw;
    logic [TAG_W-1:0]      r_cur, r_mz;
    t_cmd                  r_cmd;
    logic signed [Y_W-1:0] r_mean, r_rmean;
    logic [CNT_W-1:0]      r_cnt, r_rcnt;
    logic signed [33:0]    r_prod;
    logic [DVW-1:0]        r_rem, r_dvs;
    logic [Y_W-1:0]        r_dq;
    logic                  r_neg;
    logic [2:0]            r_it;

    logic signed [Y_W-1:0] mean_e;
    logic [CNT_W-1:0]      cnt_e;
    logic signed [33:0]    num;
    logic [33:0]           mag;
    logic [DVW:0]          t1, t2;
    logic                  ge1, ge2;
    logic [DVW-1:0]        rem1, rem2;
    logic signed [Y_W-1:0] qs;
    logic [CNT_W-1:0]      ncnt;
    logic                  take;

    assign mean_e = (r_rdata.tag >= r_mz) ? r_rdata.mean : '0;
    assign cnt_e  = (r_rdata.tag == r_cur) ? r_rdata.cnt : '0;
    assign num    = r_prod + 34'(r_cmd.y);
    assign mag    = num[33] ? 34'(-num) : 34'(num);
    assign t1     = {r_rem, r_dq[Y_W-1]};
    assign ge1    = t1 >= {1'b0, r_dvs};
    assign rem1   = ge1 ? DVW'(t1 - {1'b0, r_dvs}) : DVW'(t1);
    assign t2     = {rem1, r_dq[Y_W-2]};
    assign ge2    = t2 >= {1'b0, r_dvs};
    assign rem2   = ge2 ? DVW'(t2 - {1'b0, r_dvs}) : DVW'(t2);
    assign qs     = r_neg ? -$signed(r_dq) : $signed(r_dq);
    assign ncnt   = (r_cnt == CNT_MAX) ? CNT_MAX : r_cnt + 1'b1;
    assign take   = !o_valid || i_ready;

    assign o_pop = (r_st == B_IDLE) && !i_empty;

    always_comb begin
        rd_addr = (r_st == B_IDLE) ? AW'(i_head.addr) : r_sw;
        we      = 1'b0;
        wr_addr = r_sw;
        wr_data = '0;
        case (r_st)
            B_INIT: begin
                we = 1'b1;
            end
            B_WR: begin
                we           = 1'b1;
                wr_addr      = AW'(r_cmd.addr);
                wr_data.mean = qs;
                wr_data.cnt  = ncnt;
                wr_data.tag  = r_cur;
            end
            B_RB_WR: begin
                we           = 1'b1;
                wr_data.mean = i_keep ? mean_e : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wr_addr] <= wr_data;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_INIT;
            r_sw    <= '0;
            r_cur   <= '0;
            r_mz    <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_st != B_EMIT) o_valid <= 1'b0;
            case (r_st)
                B_INIT: begin
                    r_sw <= r_sw + 1'b1;
                    if (r_sw == AW'(DEPTH - 1)) begin
                        r_sw <= '0;
                        r_st <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        case (i_head.kind)
                            K_ADD, K_READ: r_st <= B_LOAD;
                            K_CLR: begin
                                if (r_cur == TAG_MAX) begin
                                    r_sw <= '0;
                                    r_st <= B_RB_RD;
                                end else begin
                                    r_cur <= r_cur + 1'b1;
                                    if (!i_keep) r_mz <= r_cur + 1'b1;
                                    r_st <= B_EMIT;
                                end
                            end
                            default: r_st <= B_EMIT;
                        endcase
                    end
                end
                B_LOAD: r_st <= (r_cmd.kind == K_READ) ? B_EMIT : B_MUL;
                B_MUL:  r_st <= B_NUM;
                B_NUM:  r_st <= B_DIV;
                B_DIV:  if (r_it == 3'd6) r_st <= B_WR;
                B_WR:   r_st <= B_EMIT;
                B_EMIT: begin
                    if (take) begin
                        o_valid <= 1'b1;
                        r_st    <= B_IDLE;
                    end
                end
                B_RB_RD: r_st <= B_RB_WR;
                B_RB_WR: begin
                    if (r_sw == AW'(DEPTH - 1)) begin
                        r_cur <= '0;
                        r_mz  <= '0;
                        r_st  <= B_EMIT;
                    end else begin
                        r_sw <= r_sw + 1'b1;
                        r_st <= B_RB_RD;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            B_IDLE: begin
                r_cmd   <= i_head;
                r_rmean <= '0;
                r_rcnt  <= '0;
            end
            B_LOAD: begin
                r_rmean <= mean_e;
                r_rcnt  <= cnt_e;
                r_mean  <= mean_e;
                r_cnt   <= cnt_e;
            end
            B_MUL: begin
                r_prod <= 34'(r_mean) * $signed(34'(r_cnt));
            end
            B_NUM: begin
                r_neg <= num[33];
                r_rem <= DVW'(mag >> Y_W);
                r_dq  <= mag[Y_W-1:0];
                r_dvs <= DVW'(r_cnt) + 1'b1;
                r_it  <= '0;
            end
            B_DIV: begin
                r_rem <= rem2;
                r_dq  <= {r_dq[Y_W-3:0], ge1, ge2};
                r_it  <= r_it + 1'b1;
            end
            B_WR: begin
                r_rmean <= qs;
                r_rcnt  <= ncnt;
            end
            B_EMIT: begin
                if (take) begin
                    o_ok   <= (r_cmd.kind == K_ADD) || (r_cmd.kind == K_READ);
                    o_row  <= r_cmd.row;
                    o_col  <= r_cmd.col;
                    o_mean <= r_rmean;
                    o_cnt  <= r_rcnt;
                end
            end
            default: begin
            end
        endcase
    end

    a_epoch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mz <= r_cur) else $error("mean epoch ahead of frame epoch");
    a_no_pop_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_INIT || r_st == B_RB_RD || r_st == B_RB_WR) |-> !o_pop)
        else $error("queue popped during sweep");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_DIV) |-> (r_it <= 3'd6)) else $error("divider overran");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == B_DIV && r_it == 3'd6) |=> (r_st == B_WR))
        else $error("divider did not finish");

endmodule
`default_nettype wire

/* rtl/core/height_grid_running_mean.sv */
`default_nettype none
// Add: the add rate is set by the back end's 2-bit-per-cycle divider and memory
// read-modify-write; the front end keeps taking points meanwhile until the FIFO fills.
// Read, clear, rejected points: paced by the front end, which pushes each before the next.
// Reset (sync, active low): a pass over every cell zeroes the cell memory first.
// Every 256th clear rewrites the memory, reading then writing back each cell in turn.
module height_grid_running_mean #(
    parameter int GRID_SIDE = hgrm_pkg::GRID_SIDE_DEF,
    parameter int CELL_MM   = hgrm_pkg::CELL_MM_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,  // x_mm, z_mm, y_mm, read_row, read_col
    input  wire  [1:0]  i_s_tuser,  // action
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [55:0] o_m_tdata,  // row, col, mean_mm, count
    output logic [0:0]  o_m_tuser,  // in_range
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data
);
    import hgrm_pkg::*;

    t_cfg                  r_cfg;
    logic                  push, full, pop, empty;
    t_cmd                  cmd, head;
    logic                  ok;
    logic [RC_W-1:0]       row, col;
    logic signed [Y_W-1:0] mean;
    logic [CNT_W-1:0]      cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_min <= -16'sd2000;
            r_cfg.x_max <= 16'sd2000;
            r_cfg.z_min <= -16'sd2000;
            r_cfg.z_max <= 16'sd2000;
            r_cfg.keep  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_XMIN: r_cfg.x_min <= i_cfg_data;
                CFG_XMAX: r_cfg.x_max <= i_cfg_data;
                CFG_ZMIN: r_cfg.z_min <= i_cfg_data;
                CFG_ZMAX: r_cfg.z_max <= i_cfg_data;
                CFG_KEEP: r_cfg.keep  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    hgrm_front #(.GRID_SIDE(GRID_SIDE), .CELL_MM(CELL_MM)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_action (i_s_tuser),
        .i_x      (i_s_tdata[15:0]),
        .i_z      (i_s_tdata[31:16]),
        .i_y      (i_s_tdata[45:32]),
        .i_rr     (i_s_tdata[54:46]),
        .i_rc     (i_s_tdata[63:55]),
        .i_cfg    (r_cfg),
        .o_push   (push),
        .o_cmd    (cmd),
        .i_full   (full)
    );

    hgrm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    hgrm_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .i_keep  (r_cfg.keep),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_ok    (ok),
        .o_row   (row),
        .o_col   (col),
        .o_mean  (mean),
        .o_cnt   (cnt)
    );

    assign o_m_tuser = ok;
    assign o_m_tdata = {5'd0, cnt, mean, col, row};

endmodule
`default_nettype wire
